// File: rtl/core/lssf_pkg.sv
// Shared types, codes and helpers for the link setup supervision block.
package lssf_pkg;

	// Input commands
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_OPEN  = 2'd2;
	localparam logic [1:0] CMD_CLOSE = 2'd3;

	// Supervision frame control codes
	localparam logic [7:0] CTL_SET  = 8'h03;
	localparam logic [7:0] CTL_UA   = 8'h05;
	localparam logic [7:0] CTL_DISC = 8'h0B;

	// Configuration register indexes
	localparam logic [2:0] REG_ROLE    = 3'd0;
	localparam logic [2:0] REG_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_RETRIES = 3'd2;
	localparam logic [2:0] REG_FLAG    = 3'd3;
	localparam logic [2:0] REG_ADDRESS = 3'd4;

	localparam int          CFG_AW      = 5;
	localparam logic [2:0]  FRAME_LAST  = 3'd4;

	typedef enum logic [3:0] {
		PH_IDLE          = 4'd0,
		PH_WAIT_UA       = 4'd1,
		PH_WAIT_SET      = 4'd2,
		PH_OPEN          = 4'd3,
		PH_WAIT_DISC     = 4'd4,
		PH_WAIT_CLOSE_UA = 4'd5,
		PH_CLOSED        = 4'd6,
		PH_FAILED        = 4'd7,
		PH_RX_WAIT_DISC  = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		RS_START = 3'd0,
		RS_FLAG  = 3'd1,
		RS_ADDR  = 3'd2,
		RS_CTRL  = 3'd3,
		RS_CHECK = 3'd4
	} rs_t;

	typedef enum logic [1:0] {
		SEND_NONE = 2'd0,
		SEND_SET  = 2'd1,
		SEND_UA   = 2'd2,
		SEND_DISC = 2'd3
	} send_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
		logic [3:0] link_phase;
	} out_item_t;

	typedef struct packed {
		logic        role_receiver;
		logic [15:0] timeout_ticks;
		logic [2:0]  max_retries;
		logic [7:0]  flag_byte;
		logic [7:0]  address_byte;
	} cfg_t;

	// One unit of work handed from the front to the back
	typedef struct packed {
		send_t  send;
		phase_t phase;
	} job_t;

	// Queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] ctl_of(send_t s);
		logic [7:0] c;
		case (s)
			SEND_SET:  c = CTL_SET;
			SEND_UA:   c = CTL_UA;
			SEND_DISC: c = CTL_DISC;
			default:   c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/lssf_front.sv
// Front end: takes requests, runs the link phase machine and byte recognizer, queues jobs.
module lssf_front import lssf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      take,
	input  in_item_t  item,
	output job_t      job
);

	phase_t      phase_q, phase_d;
	rs_t         rs_q, rs_d;
	logic [15:0] timer_q, timer_d;
	logic [2:0]  count_q, count_d;

	logic [7:0] want_ctl;
	logic       want_vld;
	logic [7:0] chk;
	rs_t        rs_rec;
	logic       frame_done;
	logic       open_ok;
	logic       set_ok;
	logic [2:0] count_base;

	// Expected frame for the current phase
	always_comb begin
		want_vld = 1'b1;
		case (phase_q)
			PH_WAIT_UA, PH_WAIT_CLOSE_UA: want_ctl = CTL_UA;
			PH_WAIT_SET:                  want_ctl = CTL_SET;
			PH_WAIT_DISC, PH_RX_WAIT_DISC: want_ctl = CTL_DISC;
			default: begin
				want_ctl = 8'h00;
				want_vld = 1'b0;
			end
		endcase
	end

	assign chk = cfg.address_byte ^ want_ctl;

	// Recognizer step on one byte
	always_comb begin
		frame_done = 1'b0;
		case (rs_q)
			RS_FLAG: begin
				if (item.rx_byte == cfg.address_byte)   rs_rec = RS_ADDR;
				else if (item.rx_byte != cfg.flag_byte) rs_rec = RS_START;
				else                                    rs_rec = RS_FLAG;
			end
			RS_ADDR: begin
				if (item.rx_byte == cfg.flag_byte) rs_rec = RS_FLAG;
				else if (item.rx_byte == want_ctl) rs_rec = RS_CTRL;
				else                               rs_rec = RS_START;
			end
			RS_CTRL: begin
				if (item.rx_byte == cfg.flag_byte) rs_rec = RS_FLAG;
				else if (item.rx_byte == chk)      rs_rec = RS_CHECK;
				else                               rs_rec = RS_START;
			end
			RS_CHECK: begin
				rs_rec     = RS_START;
				frame_done = (item.rx_byte == cfg.flag_byte);
			end
			default: rs_rec = (item.rx_byte == cfg.flag_byte) ? RS_FLAG : RS_START;
		endcase
	end

	assign open_ok    = (phase_q == PH_IDLE) || (phase_q == PH_CLOSED) || (phase_q == PH_FAILED);
	assign count_base = (item.command == CMD_OPEN) ? 3'd0 : count_q;
	assign set_ok     = count_base < cfg.max_retries;

	// Next state
	always_comb begin
		phase_d = phase_q;
		rs_d    = rs_q;
		timer_d = timer_q;
		count_d = count_q;
		case (item.command)
			CMD_BYTE: begin
				if (!want_vld) begin
					rs_d = RS_START;
				end else if (frame_done) begin
					rs_d = RS_START;
					case (phase_q)
						PH_WAIT_UA: begin
							timer_d = 16'd0;
							phase_d = PH_OPEN;
						end
						PH_WAIT_SET:     phase_d = PH_OPEN;
						PH_WAIT_DISC:    phase_d = PH_CLOSED;
						PH_RX_WAIT_DISC: phase_d = PH_WAIT_CLOSE_UA;
						default:         phase_d = PH_CLOSED;
					endcase
				end else begin
					rs_d = rs_rec;
				end
			end
			CMD_TICK: begin
				if (phase_q == PH_WAIT_UA) begin
					if (timer_q <= 16'd1) begin
						if (set_ok) begin
							count_d = count_base + 3'd1;
							timer_d = cfg.timeout_ticks;
						end else begin
							timer_d = 16'd0;
							phase_d = PH_FAILED;
						end
					end else begin
						timer_d = timer_q - 16'd1;
					end
				end
			end
			CMD_OPEN: begin
				if (open_ok) begin
					rs_d    = RS_START;
					count_d = 3'd0;
					timer_d = 16'd0;
					if (cfg.role_receiver) begin
						phase_d = PH_WAIT_SET;
					end else if (set_ok) begin
						count_d = count_base + 3'd1;
						timer_d = cfg.timeout_ticks;
						phase_d = PH_WAIT_UA;
					end else begin
						phase_d = PH_FAILED;
					end
				end
			end
			default: begin
				if (phase_q == PH_OPEN) begin
					rs_d    = RS_START;
					phase_d = cfg.role_receiver ? PH_RX_WAIT_DISC : PH_WAIT_DISC;
				end
			end
		endcase
	end

	// Outputs: frame to send
	always_comb begin
		job.send  = SEND_NONE;
		job.phase = phase_d;
		case (item.command)
			CMD_BYTE: begin
				if (want_vld && frame_done) begin
					case (phase_q)
						PH_WAIT_SET, PH_WAIT_DISC: job.send = SEND_UA;
						PH_RX_WAIT_DISC:           job.send = SEND_DISC;
						default:                   job.send = SEND_NONE;
					endcase
				end
			end
			CMD_TICK: begin
				if (phase_q == PH_WAIT_UA && timer_q <= 16'd1) job.send = SEND_SET;
			end
			CMD_OPEN: begin
				if (open_ok && !cfg.role_receiver) job.send = SEND_SET;
			end
			default: begin
				if (phase_q == PH_OPEN && !cfg.role_receiver) job.send = SEND_DISC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rs_q    <= RS_START;
			timer_q <= 16'd0;
			count_q <= 3'd0;
		end else if (take) begin
			phase_q <= phase_d;
			rs_q    <= rs_d;
			timer_q <= timer_d;
			count_q <= count_d;
		end
	end

endmodule

// File: rtl/core/lssf_queue.sv
// Two-entry job queue between the front and the back.
module lssf_queue import lssf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      head,
	output q_status_t status
);

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head         = mem_q[rd_q];
	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/core/lssf_back.sv
// Back end: expands queued jobs into result bytes behind an output register.
module lssf_back import lssf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  job_t      head,
	input  q_status_t status,
	output logic      pop,
	input  logic      out_stall,
	output logic      out_valid,
	output out_item_t out_data
);

	job_t      job_q;
	logic      active_q;
	logic [2:0] idx_q;
	logic      out_valid_q;
	out_item_t out_data_q;

	job_t      src;
	logic      have;
	logic      out_free;
	logic      emit;
	out_item_t res;
	logic [7:0] ctl;

	assign src      = active_q ? job_q : head;
	assign have     = active_q || !status.empty;
	assign out_free = !out_valid_q || !out_stall;
	assign emit     = out_free && have;
	assign pop      = emit && !active_q;
	assign ctl      = ctl_of(src.send);

	always_comb begin
		res.link_phase = src.phase;
		if (src.send == SEND_NONE) begin
			res.tx_valid = 1'b0;
			res.tx_byte  = 8'h00;
			res.last     = 1'b1;
		end else begin
			res.tx_valid = 1'b1;
			res.last     = (idx_q == FRAME_LAST);
			case (idx_q)
				3'd0:    res.tx_byte = cfg.flag_byte;
				3'd1:    res.tx_byte = cfg.address_byte;
				3'd2:    res.tx_byte = ctl;
				3'd3:    res.tx_byte = cfg.address_byte ^ ctl;
				default: res.tx_byte = cfg.flag_byte;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			job_q      <= src;
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) out_valid_q <= emit;
			if (emit) begin
				if (res.last) begin
					active_q <= 1'b0;
					idx_q    <= 3'd0;
				end else begin
					active_q <= 1'b1;
					idx_q    <= idx_q + 3'd1;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/core/link_setup_supervision_fsm_unit.sv
// Top level of the serial link setup and supervision block with its register port.
// Runs the connection handshake of a serial link with five-byte supervision frames
// (flag, address, control, address XOR control, flag). Each request is a received
// byte, a timer tick, an open or a close; it yields either one result with tx_valid
// low, or the five bytes of a SET, UA or DISC frame, and every result carries the
// link phase after the request. The front end takes one request per cycle unless the
// queue is full, updates the phase, the frame recognizer, the retry timer and the send
// count in that cycle, and posts a job into a two-entry queue; the back end turns jobs
// into results one byte per cycle through an output register, unless out_stall holds
// them. The back end's one byte per cycle output sets the sustained rate, and the
// queue lets the front keep taking requests while a frame drains. Registers sit at
// byte addresses 0 (role, 1 for receiver), 4 (timeout ticks), 8 (retry limit), 12
// (flag byte) and 16 (address byte); write them only while the block is idle. No
// clearing pass follows reset.
module link_setup_supervision_fsm_unit import lssf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;
	logic       take;
	job_t       front_job;
	job_t       head;
	q_status_t  q_status;
	logic       pop;

	// Register port: always ready, word addressed
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.role_receiver <= 1'b0;
			cfg_q.timeout_ticks <= 16'd3;
			cfg_q.max_retries   <= 3'd3;
			cfg_q.flag_byte     <= 8'h5C;
			cfg_q.address_byte  <= 8'h01;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ROLE:    cfg_q.role_receiver <= pwdata[0];
				REG_TIMEOUT: cfg_q.timeout_ticks <= pwdata[15:0];
				REG_RETRIES: cfg_q.max_retries   <= pwdata[2:0];
				REG_FLAG:    cfg_q.flag_byte     <= pwdata[7:0];
				REG_ADDRESS: cfg_q.address_byte  <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	// Read back: unused addresses read as zero
	always_comb begin
		case (reg_idx)
			REG_ROLE:    prdata = {31'd0, cfg_q.role_receiver};
			REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_ticks};
			REG_RETRIES: prdata = {29'd0, cfg_q.max_retries};
			REG_FLAG:    prdata = {24'd0, cfg_q.flag_byte};
			REG_ADDRESS: prdata = {24'd0, cfg_q.address_byte};
			default:     prdata = 32'd0;
		endcase
	end

	// Hold requests only while the queue has no room
	assign in_stall = q_status.full;
	assign take     = in_valid && !q_status.full;

	lssf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.take   (take),
		.item   (in_data),
		.job    (front_job)
	);

	lssf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_job (front_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	lssf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.status    (q_status),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// A result that sends nothing always closes its request
	a_idle_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.tx_valid) |-> (out_data.last && out_data.tx_byte == 8'h00))
		else $error("result without a byte is not marked last");

	// Frame bytes follow one another without a gap
	a_frame_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.tx_valid && !out_data.last && !out_stall)
			|=> (out_valid && out_data.tx_valid))
		else $error("gap inside a frame");

	// Phase stays fixed across the bytes of one frame
	a_frame_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.tx_valid && !out_data.last && !out_stall)
			|=> (out_data.link_phase == $past(out_data.link_phase)))
		else $error("link phase changed inside a frame");

endmodule
